// ----- src/rpsb_pkg.sv -----
package rpsb_pkg;

    // Fixed field widths of the result beat and the configuration port.
    localparam int BIN_W      = 6;
    localparam int CNT_W      = 19;
    localparam int AVG_W      = 40;
    localparam int SUM_W      = 64;
    localparam int CFG_W      = 6;
    localparam int CFG_ADDR_W = 2;

    // Register widths.
    localparam int DIMS_W = 2;
    localparam int GRID_W = 3;
    localparam int NORM_W = 6;

    // Geometry arithmetic width: holds 2^6 and every value derived from it.
    localparam int NP_W = 7;

    // Divider iteration counter width (one quotient bit per cycle).
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DIMS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NORM = 2'd2;

    // Register reset values and codes.
    localparam logic [DIMS_W-1:0] DIMS_RST   = 2'd3;
    localparam logic [DIMS_W-1:0] DIMS_3D    = 2'd3;
    localparam logic [GRID_W-1:0] GRID_RST   = 3'd6;
    localparam logic [GRID_W-1:0] GRID_L2_LO = 3'd1;
    localparam logic [GRID_W-1:0] GRID_L2_HI = 3'd6;
    localparam logic [NORM_W-1:0] NORM_RST   = 6'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_LOOK,
        ST_ACC,
        ST_ERD,
        ST_DINIT,
        ST_DIV,
        ST_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic sqrt_step;
        logic lookup;
        logic acc;
        logic erd;
        logic dinit;
        logic dstep;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_last;
        logic frame_end;
        logic div_last;
        logic out_free;
        logic last_shell;
    } t_sts;

endpackage

// ----- src/rpsb_in_if.sv -----
interface rpsb_in_if #(
    parameter int SAMPLE_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] re_part;
    logic signed [SAMPLE_BITS-1:0] im_part;

    modport source (output valid, output re_part, output im_part, input ready);
    modport sink   (input valid, input re_part, input im_part, output ready);
endinterface

// ----- src/rpsb_out_if.sv -----
interface rpsb_out_if;
    logic                          valid;
    logic                          ready;
    logic [rpsb_pkg::BIN_W-1:0]    bin_index;
    logic [rpsb_pkg::CNT_W-1:0]    mode_count;
    logic [rpsb_pkg::AVG_W-1:0]    average_power;
    logic                          last_bin;

    modport source (
        output valid, output bin_index, output mode_count,
        output average_power, output last_bin, input ready
    );
    modport sink (
        input valid, input bin_index, input mode_count,
        input average_power, input last_bin, output ready
    );
endinterface

// ----- src/rpsb_ctrl.sv -----
module rpsb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rpsb_pkg::t_sts i_sts,
    output rpsb_pkg::t_cmd o_cmd
);

    rpsb_pkg::t_state r_state;
    rpsb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpsb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rpsb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = rpsb_pkg::ST_SQRT;
                end
            end
            rpsb_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = rpsb_pkg::ST_LOOK;
                end
            end
            rpsb_pkg::ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = rpsb_pkg::ST_ACC;
            end
            rpsb_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.frame_end ? rpsb_pkg::ST_ERD : rpsb_pkg::ST_IDLE;
            end
            rpsb_pkg::ST_ERD: begin
                o_cmd.erd = 1'b1;
                n_state   = rpsb_pkg::ST_DINIT;
            end
            rpsb_pkg::ST_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_state     = rpsb_pkg::ST_DIV;
            end
            rpsb_pkg::ST_DIV: begin
                o_cmd.dstep = 1'b1;
                if (i_sts.div_last) begin
                    n_state = rpsb_pkg::ST_LOAD;
                end
            end
            rpsb_pkg::ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.last_shell ? rpsb_pkg::ST_IDLE : rpsb_pkg::ST_ERD;
                end
            end
            default: begin
                n_state = rpsb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rpsb_dp.sv -----
module rpsb_dp #(
    parameter int GRID_MAX    = 64,
    parameter int SHELLS      = 33,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rpsb_pkg::t_cmd                        i_cmd,
    output rpsb_pkg::t_sts                        o_sts,
    input  logic signed [SAMPLE_BITS-1:0]         i_re,
    input  logic signed [SAMPLE_BITS-1:0]         i_im,
    input  logic                                  i_cfg_wr_en,
    input  logic [rpsb_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [rpsb_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [rpsb_pkg::BIN_W-1:0]            o_bin_index,
    output logic [rpsb_pkg::CNT_W-1:0]            o_mode_count,
    output logic [rpsb_pkg::AVG_W-1:0]            o_average_power,
    output logic                                  o_last_bin
);

    localparam int NP_W  = rpsb_pkg::NP_W;
    localparam int SUM_W = rpsb_pkg::SUM_W;
    localparam int CNT_W = rpsb_pkg::CNT_W;
    localparam int POS_W = $clog2(GRID_MAX);
    localparam int R2_W  = $clog2(3 * (GRID_MAX / 2) * (GRID_MAX / 2) + 1);
    localparam int RT_W  = POS_W + 1;
    localparam int RC_W  = $clog2(RT_W);
    localparam int SH_W  = $clog2(SHELLS);
    localparam int CW    = (RT_W > NP_W) ? RT_W : NP_W;
    localparam int P_W   = 2 * SAMPLE_BITS;
    localparam logic [NP_W-1:0] N_CAP = NP_W'(GRID_MAX - GRID_MAX % 2);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    // Configuration registers.
    logic [rpsb_pkg::DIMS_W-1:0] r_dims;
    logic [rpsb_pkg::GRID_W-1:0] r_grid;
    logic [rpsb_pkg::NORM_W-1:0] r_norm;
    logic                        geo_wr;

    // Raster position.
    logic [POS_W-1:0] r_pos_x;
    logic [POS_W-1:0] r_pos_y;
    logic [POS_W-1:0] r_pos_z;

    // Per-coefficient working registers.
    logic [P_W-1:0]   r_re_sq;
    logic [P_W-1:0]   r_im_sq;
    logic             r_w2;
    logic             r_frame_end;
    logic [R2_W-1:0]  r_r2;
    logic [RT_W-1:0]  r_root;
    logic [RC_W-1:0]  r_rcnt;
    logic [SH_W-1:0]  r_kbin;
    logic             r_hit;

    // Shell store.
    t_entry           mem [SHELLS];
    logic [SHELLS-1:0] r_vld;
    t_entry           r_rd;
    logic             r_rd_vld;

    // Emission and divider.
    logic [SH_W-1:0]      r_eidx;
    logic [SUM_W-1:0]     r_num;
    logic [CNT_W:0]       r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [rpsb_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic                 r_out_vld;
    logic [rpsb_pkg::BIN_W-1:0] r_o_bin;
    logic [CNT_W-1:0]     r_o_cnt;
    logic [rpsb_pkg::AVG_W-1:0] r_o_avg;
    logic                 r_o_last;

    // Geometry.
    logic [rpsb_pkg::GRID_W-1:0] g_sat;
    logic [NP_W-1:0] n_pow;
    logic [NP_W-1:0] n_len;
    logic [NP_W-1:0] hn;
    logic [NP_W-1:0] shells_all;
    logic [NP_W-1:0] shells;
    logic            three;
    logic [NP_W-1:0] px;
    logic [NP_W-1:0] py;
    logic [NP_W-1:0] pz;
    logic [NP_W-1:0] my_full;
    logic [NP_W-1:0] mz_full;
    logic [POS_W-1:0] mx;
    logic [POS_W-1:0] my;
    logic [POS_W-1:0] mz;
    logic [2*POS_W-1:0] sq_x;
    logic [2*POS_W-1:0] sq_y;
    logic [2*POS_W-1:0] sq_z;
    logic [R2_W-1:0] r2;
    logic x_last;
    logic y_last;
    logic z_last;

    logic signed [P_W-1:0] re_sq_s;
    logic signed [P_W-1:0] im_sq_s;

    // Square root and rounding.
    logic [RT_W-1:0]   trial;
    logic [2*RT_W-1:0] trial_sq;
    logic [2*RT_W-1:0] r2_ext;
    logic [2*RT_W-1:0] root_sq;
    logic [2*RT_W-1:0] rem_sq;
    logic              round_up;
    logic [RT_W-1:0]   kbin;
    logic              hit;
    logic [SH_W-1:0]   rd_addr;

    // Accumulate.
    logic [P_W:0]      p_sum;
    logic [SUM_W-1:0]  p_w;
    logic [SUM_W-1:0]  base_sum;
    logic [CNT_W-1:0]  base_cnt;
    t_entry            wr_entry;

    // Divide step.
    logic [CNT_W:0]    d_trial;
    logic              d_ge;
    logic [SUM_W-1:0]  quot_sh;

    always_comb begin
        if (r_grid < rpsb_pkg::GRID_L2_LO) begin
            g_sat = rpsb_pkg::GRID_L2_LO;
        end else if (r_grid > rpsb_pkg::GRID_L2_HI) begin
            g_sat = rpsb_pkg::GRID_L2_HI;
        end else begin
            g_sat = r_grid;
        end
        n_pow      = NP_W'(1) << g_sat;
        n_len      = (n_pow > N_CAP) ? N_CAP : n_pow;
        hn         = n_len >> 1;
        shells_all = hn + NP_W'(1);
        shells     = (shells_all > NP_W'(SHELLS)) ? NP_W'(SHELLS) : shells_all;
        three      = (r_dims == rpsb_pkg::DIMS_3D);

        px = NP_W'(r_pos_x);
        py = NP_W'(r_pos_y);
        pz = NP_W'(r_pos_z);
        my_full = (py <= hn) ? py : n_len - py;
        mz_full = (pz <= hn) ? pz : n_len - pz;
        mx = r_pos_x;
        my = my_full[POS_W-1:0];
        mz = three ? mz_full[POS_W-1:0] : '0;
        sq_x = {{POS_W{1'b0}}, mx} * {{POS_W{1'b0}}, mx};
        sq_y = {{POS_W{1'b0}}, my} * {{POS_W{1'b0}}, my};
        sq_z = {{POS_W{1'b0}}, mz} * {{POS_W{1'b0}}, mz};
        r2   = R2_W'(sq_x) + R2_W'(sq_y) + R2_W'(sq_z);

        x_last = (px == hn);
        y_last = (py + NP_W'(1) == n_len);
        z_last = (pz + NP_W'(1) == n_len);
    end

    assign re_sq_s = P_W'(i_re) * P_W'(i_re);
    assign im_sq_s = P_W'(i_im) * P_W'(i_im);

    // One result bit of the integer square root per cycle, MSB first.
    always_comb begin
        trial         = r_root;
        trial[r_rcnt] = 1'b1;
        trial_sq      = {{RT_W{1'b0}}, trial} * {{RT_W{1'b0}}, trial};
        r2_ext        = (2 * RT_W)'(r_r2);
        root_sq       = {{RT_W{1'b0}}, r_root} * {{RT_W{1'b0}}, r_root};
        rem_sq        = r2_ext - root_sq;
        round_up      = (rem_sq > (2 * RT_W)'(r_root));
        kbin          = r_root + RT_W'(round_up);
        hit           = (CW'(kbin) < CW'(shells));
        rd_addr       = i_cmd.erd ? r_eidx : (hit ? kbin[SH_W-1:0] : '0);
    end

    always_comb begin
        p_sum    = {1'b0, r_re_sq} + {1'b0, r_im_sq};
        p_w      = r_w2 ? (SUM_W'(p_sum) << 1) : SUM_W'(p_sum);
        base_sum = r_rd_vld ? r_rd.sum : '0;
        base_cnt = r_rd_vld ? r_rd.cnt : '0;
        wr_entry.sum = base_sum + p_w;
        wr_entry.cnt = base_cnt + (r_w2 ? CNT_W'(2) : CNT_W'(1));
    end

    always_comb begin
        d_trial = {r_rem[CNT_W-1:0], r_num[SUM_W-1]};
        d_ge    = (d_trial >= {1'b0, r_div});
        quot_sh = r_num >> r_norm;
    end

    assign geo_wr = i_cfg_wr_en &&
                    (i_cfg_addr == rpsb_pkg::REG_DIMS || i_cfg_addr == rpsb_pkg::REG_GRID);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims    <= rpsb_pkg::DIMS_RST;
            r_grid    <= rpsb_pkg::GRID_RST;
            r_norm    <= rpsb_pkg::NORM_RST;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_vld     <= '0;
            r_eidx    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    rpsb_pkg::REG_DIMS: r_dims <= i_cfg_wdata[rpsb_pkg::DIMS_W-1:0];
                    rpsb_pkg::REG_GRID: r_grid <= i_cfg_wdata[rpsb_pkg::GRID_W-1:0];
                    rpsb_pkg::REG_NORM: r_norm <= i_cfg_wdata[rpsb_pkg::NORM_W-1:0];
                    default: ;
                endcase
            end

            if (geo_wr) begin
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_pos_z <= '0;
                r_vld   <= '0;
                r_eidx  <= '0;
            end else begin
                if (i_cmd.accept) begin
                    if (x_last) begin
                        r_pos_x <= '0;
                        if (y_last) begin
                            r_pos_y <= '0;
                            if (three && !z_last) begin
                                r_pos_z <= r_pos_z + POS_W'(1);
                            end else begin
                                r_pos_z <= '0;
                            end
                        end else begin
                            r_pos_y <= r_pos_y + POS_W'(1);
                        end
                    end else begin
                        r_pos_x <= r_pos_x + POS_W'(1);
                    end
                end
                if (i_cmd.acc && r_hit) begin
                    r_vld[r_kbin] <= 1'b1;
                end
                if (i_cmd.acc) begin
                    r_eidx <= '0;
                end
                if (i_cmd.load) begin
                    r_vld[r_eidx] <= 1'b0;
                    r_eidx        <= r_eidx + SH_W'(1);
                end
            end

            if (i_cmd.load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_re_sq     <= $unsigned(re_sq_s);
            r_im_sq     <= $unsigned(im_sq_s);
            r_w2        <= !(r_pos_x == '0 || x_last);
            r_frame_end <= x_last && y_last && (!three || z_last);
            r_r2        <= r2;
            r_root      <= '0;
            r_rcnt      <= RC_W'(RT_W - 1);
        end
        if (i_cmd.sqrt_step) begin
            if (trial_sq <= r2_ext) begin
                r_root <= trial;
            end
            r_rcnt <= r_rcnt - RC_W'(1);
        end
        if (i_cmd.lookup) begin
            r_kbin <= kbin[SH_W-1:0];
            r_hit  <= hit;
        end
        if (i_cmd.dinit) begin
            r_num  <= base_sum;
            r_div  <= base_cnt;
            r_rem  <= '0;
            r_dcnt <= '1;
        end
        if (i_cmd.dstep) begin
            r_rem  <= d_ge ? (d_trial - {1'b0, r_div}) : d_trial;
            r_num  <= {r_num[SUM_W-2:0], d_ge};
            r_dcnt <= r_dcnt - rpsb_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_o_bin  <= rpsb_pkg::BIN_W'(r_eidx);
            r_o_cnt  <= r_div;
            r_o_avg  <= (r_div == '0) ? '0 : quot_sh[rpsb_pkg::AVG_W-1:0];
            r_o_last <= o_sts.last_shell;
        end
    end

    // Shell memory: one read and one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup || i_cmd.erd) begin
            r_rd     <= mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (i_cmd.acc && r_hit) begin
            mem[r_kbin] <= wr_entry;
        end
    end

    always_comb begin
        o_sts.sqrt_last  = (r_rcnt == '0);
        o_sts.frame_end  = r_frame_end;
        o_sts.div_last   = (r_dcnt == '0);
        o_sts.out_free   = !r_out_vld || i_out_ready;
        o_sts.last_shell = (NP_W'(r_eidx) + NP_W'(1) == shells);
    end

    assign o_out_valid     = r_out_vld;
    assign o_bin_index     = r_o_bin;
    assign o_mode_count    = r_o_cnt;
    assign o_average_power = r_o_avg;
    assign o_last_bin      = r_o_last;

endmodule

// ----- src/radial_power_spectrum_binner.sv -----
// Beat       Dir  Payload                                          Handshake
// i_coef     in   re_part, im_part (signed, SAMPLE_BITS each)      valid/ready
// o_bin      out  bin_index, mode_count, average_power, last_bin   valid/ready
// i_cfg_*    in   register index and write data                    write enable only
//
// Each coefficient passes through the bit-serial square root, whose result is
// RT_W = $clog2(GRID_MAX) + 1 bits wide; no new coefficient is taken until the
// last one has updated its shell. After the last coefficient of a frame each
// shell is divided in turn by the one-bit-per-cycle 64-bit divider.
// Reset is synchronous and active low; it restores the registers and empties
// all shells at once through per-shell valid bits. A result beat may wait on
// o_bin.ready while the next shell is already being divided.
module radial_power_spectrum_binner #(
    parameter int GRID_MAX    = 64,
    parameter int SHELLS      = 33,
    parameter int SAMPLE_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rpsb_in_if.sink                         i_coef,
    rpsb_out_if.source                      o_bin,
    input  logic                            i_cfg_wr_en,
    input  logic [rpsb_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rpsb_pkg::CFG_W-1:0]      i_cfg_wdata
);

    rpsb_pkg::t_cmd cmd;
    rpsb_pkg::t_sts sts;

    // The controller sequences accept, square root, shell update and the
    // end-of-frame report; it only sees status flags from the datapath.
    rpsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_coef.valid),
        .o_in_ready (i_coef.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the configuration, the raster position, the shell
    // memory, the square-root unit, the divider and the output register.
    rpsb_dp #(
        .GRID_MAX    (GRID_MAX),
        .SHELLS      (SHELLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_re            (i_coef.re_part),
        .i_im            (i_coef.im_part),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_ready     (o_bin.ready),
        .o_out_valid     (o_bin.valid),
        .o_bin_index     (o_bin.bin_index),
        .o_mode_count    (o_bin.mode_count),
        .o_average_power (o_bin.average_power),
        .o_last_bin      (o_bin.last_bin)
    );

endmodule
